// ===== hdl/md5_pkg.sv =====
// ---------------------------------------------------------------------------
// md5_pkg - shared types, constants and functions of the MD5 digest core
// Round constants, shift amounts, message index schedule and state types.
// ---------------------------------------------------------------------------
package md5_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_START  = 6'd56;
    localparam logic [5:0] BLOCK_LAST = 6'd63;
    localparam logic [2:0] MAX_BYTES  = 3'd4;

    typedef enum logic [2:0] {
        F_IDLE,
        F_DATA,
        F_PAD80,
        F_PADZ,
        F_LEN
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_RUN,
        B_FIN
    } back_state_t;

    // one 64-byte block on its way from front to back
    typedef struct packed {
        logic [511:0] block;
        logic         last_blk;
    } q_entry_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_s(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // message word index for step i
    function automatic logic [3:0] msg_idx(input logic [5:0] i);
        logic [3:0] g;
        case (i[5:4])
            2'd0:    g = i[3:0];
            2'd1:    g = 4'((i[3:0] * 4'd5) + 4'd1);
            2'd2:    g = 4'((i[3:0] * 4'd3) + 4'd5);
            default: g = 4'(i[3:0] * 4'd7);
        endcase
        return g;
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] t;
        t = {v, v} << s;
        return t[63:32];
    endfunction

endpackage

// ===== hdl/md5_front.sv =====
// ---------------------------------------------------------------------------
// md5_front - byte packer and padder
// Appends message bytes one per cycle, stalling when a completed block finds
// the queue full, pads the last block and hands complete blocks to the queue.
// ---------------------------------------------------------------------------
module md5_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                msg_valid,
    output logic                msg_ready,
    input  logic [31:0]         message_word,
    input  logic [2:0]          byte_count,
    input  logic                last_word,
    input  md5_pkg::q_status_t  q_stat,
    output logic                q_push,
    output md5_pkg::q_entry_t   q_wdata
);

    md5_pkg::front_state_t state_reg, state_next;

    logic [511:0] buf_reg, buf_next;
    logic [5:0]   fill_reg, fill_next;
    logic [63:0]  len_reg, len_next;
    logic [31:0]  word_reg, word_next;
    logic [2:0]   cnt_reg, cnt_next;
    logic         last_reg, last_next;
    logic [2:0]   lidx_reg, lidx_next;

    logic         accept;
    logic         push_en;
    logic         push_ok;
    logic [7:0]   push_byte;
    logic [2:0]   cnt_in;
    logic [5:0]   fill_inc;

    assign accept   = msg_valid && msg_ready;
    assign cnt_in   = (byte_count > md5_pkg::MAX_BYTES) ? md5_pkg::MAX_BYTES : byte_count;
    assign fill_inc = fill_reg + 6'd1;
    // a byte that completes a block needs room in the queue
    assign push_ok  = !((fill_reg == md5_pkg::BLOCK_LAST) && q_stat.full);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            md5_pkg::F_IDLE:
            begin
                if (accept && cnt_in != 3'd0)
                    state_next = md5_pkg::F_DATA;
                else if (accept && last_word)
                    state_next = md5_pkg::F_PAD80;
            end
            md5_pkg::F_DATA:
            begin
                if (push_ok && cnt_reg == 3'd1)
                    state_next = last_reg ? md5_pkg::F_PAD80 : md5_pkg::F_IDLE;
            end
            md5_pkg::F_PAD80, md5_pkg::F_PADZ:
            begin
                if (push_ok)
                    state_next = (fill_inc == md5_pkg::LEN_START) ? md5_pkg::F_LEN
                                                                   : md5_pkg::F_PADZ;
            end
            md5_pkg::F_LEN:
            begin
                if (push_ok && lidx_reg == 3'd7)
                    state_next = md5_pkg::F_IDLE;
            end
            default: state_next = md5_pkg::F_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        msg_ready = (state_reg == md5_pkg::F_IDLE);
        push_en   = 1'b0;
        push_byte = 8'h00;
        word_next = word_reg;
        cnt_next  = cnt_reg;
        last_next = last_reg;
        lidx_next = lidx_reg;
        len_next  = len_reg;
        case (state_reg)
            md5_pkg::F_IDLE:
            begin
                if (accept)
                begin
                    word_next = message_word;
                    cnt_next  = cnt_in;
                    last_next = last_word;
                    lidx_next = 3'd0;
                end
            end
            md5_pkg::F_DATA:
            begin
                push_en   = 1'b1;
                push_byte = word_reg[7:0];
                if (push_ok)
                begin
                    word_next = {8'h00, word_reg[31:8]};
                    cnt_next  = cnt_reg - 3'd1;
                    len_next  = len_reg + 64'd8;
                end
            end
            md5_pkg::F_PAD80:
            begin
                push_en   = 1'b1;
                push_byte = md5_pkg::PAD_BYTE;
            end
            md5_pkg::F_PADZ:
            begin
                push_en   = 1'b1;
                push_byte = 8'h00;
            end
            md5_pkg::F_LEN:
            begin
                push_en   = 1'b1;
                push_byte = len_reg[{lidx_reg, 3'b000} +: 8];
                if (push_ok)
                begin
                    lidx_next = lidx_reg + 3'd1;
                    if (lidx_reg == 3'd7)
                        len_next = 64'd0;
                end
            end
            default: ;
        endcase

        buf_next = buf_reg;
        buf_next[{fill_reg, 3'b000} +: 8] = push_byte;
        fill_next = (push_en && push_ok) ? fill_inc : fill_reg;

        q_push           = push_en && push_ok && (fill_reg == md5_pkg::BLOCK_LAST);
        q_wdata.block    = buf_next;
        q_wdata.last_blk = (state_reg == md5_pkg::F_LEN) && (lidx_reg == 3'd7);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= md5_pkg::F_IDLE;
            fill_reg  <= 6'd0;
            len_reg   <= 64'd0;
            cnt_reg   <= 3'd0;
            last_reg  <= 1'b0;
            lidx_reg  <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
            lidx_reg  <= lidx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        if (push_en && push_ok)
            buf_reg <= buf_next;
    end

endmodule

// ===== hdl/md5_queue.sv =====
// ---------------------------------------------------------------------------
// md5_queue - two-entry block queue
// Holds padded blocks between the packer and the round engine.
// ---------------------------------------------------------------------------
module md5_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  md5_pkg::q_entry_t   wdata,
    input  logic                pop,
    output md5_pkg::q_entry_t   rdata,
    output md5_pkg::q_status_t  stat
);

    md5_pkg::q_entry_t mem_reg [2];

    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign stat.full  = (cnt_reg == 2'd2);
    assign stat.empty = (cnt_reg == 2'd0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rdata      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

// ===== hdl/md5_back.sv =====
// ---------------------------------------------------------------------------
// md5_back - MD5 round engine
// One round step per cycle over a queued block, then the chaining add and,
// on the final block, the digest output register.
// ---------------------------------------------------------------------------
module md5_back (
    input  logic                clk,
    input  logic                rst_n,
    input  md5_pkg::q_entry_t   q_rdata,
    input  md5_pkg::q_status_t  q_stat,
    output logic                q_pop,
    output logic                digest_valid,
    input  logic                digest_ready,
    output logic [63:0]         digest_low,
    output logic [63:0]         digest_high
);

    md5_pkg::back_state_t state_reg, state_next;

    logic [31:0] w_reg [16];
    logic [31:0] h_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [5:0]  step_reg;
    logic        lastb_reg;
    logic        ovalid_reg;
    logic [63:0] olow_reg, ohigh_reg;

    logic [31:0] f_val, t_val, b_new;
    logic [31:0] h_sum [4];
    logic        start;

    assign start = q_stat.empty ? 1'b0 : !(q_rdata.last_blk && ovalid_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            md5_pkg::B_IDLE: if (start) state_next = md5_pkg::B_RUN;
            md5_pkg::B_RUN:  if (step_reg == 6'd63) state_next = md5_pkg::B_FIN;
            md5_pkg::B_FIN:  state_next = md5_pkg::B_IDLE;
            default:         state_next = md5_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop = (state_reg == md5_pkg::B_IDLE) && start;
        case (step_reg[5:4])
            2'd0:    f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    f_val = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2:    f_val = b_reg ^ c_reg ^ d_reg;
            default: f_val = c_reg ^ (b_reg | ~d_reg);
        endcase
        t_val = a_reg + f_val + w_reg[md5_pkg::msg_idx(step_reg)]
              + md5_pkg::round_k(step_reg);
        b_new = b_reg + md5_pkg::rotl(t_val, md5_pkg::rot_s(step_reg));
        h_sum[0] = h_reg[0] + a_reg;
        h_sum[1] = h_reg[1] + b_reg;
        h_sum[2] = h_reg[2] + c_reg;
        h_sum[3] = h_reg[3] + d_reg;
    end

    assign digest_valid = ovalid_reg;
    assign digest_low   = olow_reg;
    assign digest_high  = ohigh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= md5_pkg::B_IDLE;
            step_reg   <= 6'd0;
            ovalid_reg <= 1'b0;
            lastb_reg  <= 1'b0;
            h_reg[0]   <= md5_pkg::IV_A;
            h_reg[1]   <= md5_pkg::IV_B;
            h_reg[2]   <= md5_pkg::IV_C;
            h_reg[3]   <= md5_pkg::IV_D;
        end
        else
        begin
            state_reg <= state_next;
            if (ovalid_reg && digest_ready)
                ovalid_reg <= 1'b0;
            case (state_reg)
                md5_pkg::B_IDLE:
                begin
                    step_reg <= 6'd0;
                    if (start)
                        lastb_reg <= q_rdata.last_blk;
                end
                md5_pkg::B_RUN:  step_reg <= step_reg + 6'd1;
                md5_pkg::B_FIN:
                begin
                    if (lastb_reg)
                    begin
                        ovalid_reg <= 1'b1;
                        h_reg[0]   <= md5_pkg::IV_A;
                        h_reg[1]   <= md5_pkg::IV_B;
                        h_reg[2]   <= md5_pkg::IV_C;
                        h_reg[3]   <= md5_pkg::IV_D;
                    end
                    else
                    begin
                        h_reg[0] <= h_sum[0];
                        h_reg[1] <= h_sum[1];
                        h_reg[2] <= h_sum[2];
                        h_reg[3] <= h_sum[3];
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            md5_pkg::B_IDLE:
            begin
                if (start)
                begin
                    for (int k = 0; k < 16; k++)
                        w_reg[k] <= q_rdata.block[32*k +: 32];
                    a_reg <= h_reg[0];
                    b_reg <= h_reg[1];
                    c_reg <= h_reg[2];
                    d_reg <= h_reg[3];
                end
            end
            md5_pkg::B_RUN:
            begin
                a_reg <= d_reg;
                d_reg <= c_reg;
                c_reg <= b_reg;
                b_reg <= b_new;
            end
            md5_pkg::B_FIN:
            begin
                if (lastb_reg)
                begin
                    olow_reg  <= {h_sum[1], h_sum[0]};
                    ohigh_reg <= {h_sum[3], h_sum[2]};
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== hdl/md5_message_digest_core.sv =====
// ---------------------------------------------------------------------------
// md5_message_digest_core - MD5 digest of a byte stream
// Packer/padder front, two-block queue, one-step-per-cycle round engine.
// ---------------------------------------------------------------------------
// channel   direction  handshake                    payload
// message   in         msg_valid / msg_ready        message_word, byte_count, last_word
// digest    out        digest_valid / digest_ready  digest_low, digest_high
//
// The front accepts a word only when idle and packs its bytes one per cycle;
// a last word adds the 0x80 pad byte, zero bytes up to byte 56 and 8 length
// bytes. The round engine takes a new 64-byte block only when idle; the
// queue lets the front pack the next block meanwhile. Reset gives the
// initial chaining words and an empty block. A full queue stalls the front
// on a byte that completes a block; a held digest stalls only a final block.
// ---------------------------------------------------------------------------
module md5_message_digest_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        msg_valid,
    output logic        msg_ready,
    input  logic [31:0] message_word,
    input  logic [2:0]  byte_count,
    input  logic        last_word,
    output logic        digest_valid,
    input  logic        digest_ready,
    output logic [63:0] digest_low,
    output logic [63:0] digest_high
);

    md5_pkg::q_status_t q_stat;
    md5_pkg::q_entry_t  q_wdata, q_rdata;
    logic               q_push, q_pop;

    md5_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_ready    (msg_ready),
        .message_word (message_word),
        .byte_count   (byte_count),
        .last_word    (last_word),
        .q_stat       (q_stat),
        .q_push       (q_push),
        .q_wdata      (q_wdata)
    );

    md5_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .stat  (q_stat)
    );

    md5_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_rdata      (q_rdata),
        .q_stat       (q_stat),
        .q_pop        (q_pop),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .digest_low   (digest_low),
        .digest_high  (digest_high)
    );

endmodule
